### rtl/bwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bwf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_MODE_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // Result fields
  localparam int VALUE_W = 4;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;

  // Smallest frame side accepted; smaller settings are raised to it
  localparam int DIM_MIN = 2;

  // Result queue depth (power of two, at least two)
  localparam int RES_DEPTH = 4;

  localparam logic [VALUE_W-1:0] MAJORITY_MIN = 4'd4;
  localparam logic [VALUE_W-1:0] FULL_COUNT   = 4'd9;

  typedef enum logic [CFG_MODE_W-1:0] {
    MODE_COUNT      = 2'd0,
    MODE_MAJORITY   = 2'd1,
    MODE_RECT_EDGE  = 2'd2,
    MODE_CROSS_EDGE = 2'd3
  } filter_mode_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  localparam filter_mode_e        MODE_RST   = MODE_MAJORITY;
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd480;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               last;
  } result_t;

  // Column triples: bit0 row above, bit1 centre row, bit2 row below
  function automatic logic [VALUE_W-1:0] filter_px(filter_mode_e mode, logic [2:0] l,
                                                   logic [2:0] m, logic [2:0] r,
                                                   logic border);
    logic [8:0]         bits;
    logic [VALUE_W-1:0] cnt;
    logic               centre;
    logic               all_set;
    logic [VALUE_W-1:0] res;
    bits = {r, m, l};
    cnt  = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + VALUE_W'(bits[i]);
    end
    centre  = m[1];
    all_set = m[0] & m[2] & l[1] & r[1];
    case (mode)
      MODE_COUNT:     res = cnt;
      MODE_MAJORITY:  res = VALUE_W'(cnt > MAJORITY_MIN);
      MODE_RECT_EDGE: res = VALUE_W'(centre && (cnt < FULL_COUNT));
      default:        res = VALUE_W'(!border && centre && !all_set);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/bwf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel / flush stream
interface bwf_in_if;
  logic valid;
  logic ready;
  logic op;
  logic pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink (input valid, input op, input pixel, output ready);
endinterface

// Filtered result stream
interface bwf_out_if;
  import bwf_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               last;

  modport source (output valid, output value, output out_row, output out_col, output last,
                  input ready);
  modport sink (input valid, input value, input out_row, input out_col, input last,
                output ready);
endinterface

`default_nettype wire

### rtl/bwf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read, new data on a same-address write
module bwf_ram #(
  parameter int DATA_W = 2,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bwf_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Result queue: up to two writes per cycle, one read per cycle
module bwf_res_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_a_i,
  input  wire logic                     push_b_i,
  input  wire bwf_pkg::result_t         data_a_i,
  input  wire bwf_pkg::result_t         data_b_i,
  output logic                          room_o,
  output logic [$clog2(DEPTH+1)-1:0]    level_o,
  bwf_out_if.source                     res_o
);
  import bwf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  result_t       mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LW-1:0] level_q, level_d;
  logic          pop;
  result_t       head;

  assign pop       = res_o.valid & res_o.ready;
  assign wr_ptr_nx = wr_ptr_q + PW'(1);

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_a_i) + PW'(push_b_i);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    level_d  = level_q + LW'(push_a_i) + LW'(push_b_i) - LW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // storage; second entry of a pair lands behind the first
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_ptr_nx] <= data_b_i;
    end
  end

  assign head          = mem_q[rd_ptr_q];
  assign res_o.valid   = (level_q != '0);
  assign res_o.value   = head.value;
  assign res_o.out_row = head.out_row;
  assign res_o.out_col = head.out_col;
  assign res_o.last    = head.last;

  // room for a full pair regardless of the reader
  assign room_o  = (level_q <= LW'(DEPTH - 2));
  assign level_o = level_q;

endmodule

`default_nettype wire

### rtl/binary_3x3_window_filter_top.sv
// Results: a result is written into the result queue by the transfer that causes it; the
// row-end pixel causes two results, written together with the second behind the first.
// Throughput: one pixel or flush item per cycle while the result queue can take a pair;
// line-buffer reads use next-state addresses; a four-entry queue absorbs row-end pairs.
// Reset: counters and window cleared, mode 1, 640 x 480; line buffers hold no reset
// value and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_3x3_window_filter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bwf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bwf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  bwf_in_if.sink                                pix_i,
  bwf_out_if.source                             res_o
);
  import bwf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ? $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;
  localparam int LVW = $clog2(RES_DEPTH + 1);
  localparam int NCOPY = 3;

  typedef struct packed {
    logic [CW-1:0] lf;
    logic [CW-1:0] f;
    logic [CW-1:0] rf;
    logic          border;
    logic          last;
  } flush_pos_t;

  function automatic logic [WW-1:0] clamp_w(logic [CFG_DIM_W-1:0] v);
    logic [WW-1:0] ve;
    ve = WW'(v);
    if (ve < WW'(DIM_MIN)) return WW'(DIM_MIN);
    if (ve > WW'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return ve;
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [CFG_DIM_W-1:0] v);
    logic [HW-1:0] ve;
    ve = HW'(v);
    if (ve < HW'(DIM_MIN)) return HW'(DIM_MIN);
    if (ve > HW'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return ve;
  endfunction

  // columns used by one flush tick
  function automatic flush_pos_t flush_pos(logic [CW-1:0] fc, logic [WW-1:0] w);
    flush_pos_t    p;
    logic [WW-1:0] wm1;
    wm1      = w - WW'(1);
    p.f      = (WW'(fc) > wm1) ? wm1[CW-1:0] : fc;
    p.lf     = (p.f == '0) ? p.f : p.f - CW'(1);
    p.last   = (WW'(p.f) + WW'(1) >= w);
    p.rf     = p.last ? p.f : p.f + CW'(1);
    p.border = (p.f == '0) || p.last;
    return p;
  endfunction

  // buffer entry: bit0 line above, bit1 line two above
  function automatic logic [2:0] buf_triple(logic [1:0] e);
    return {e[0], e[0], e[1]};
  endfunction

  filter_mode_e           mode_q, mode_d;
  logic [CFG_DIM_W-1:0]   width_q, width_d;
  logic [CFG_DIM_W-1:0]   height_q, height_d;
  logic [WW-1:0]          w_q, w_d;
  logic [HW-1:0]          h_q, h_d;

  logic [8:0]             window_q, window_d;
  logic [CW-1:0]          col_q, col_d;
  logic [RW-1:0]          row_q, row_d;
  logic [CW-1:0]          fcol_q, fcol_d;

  logic                   in_fire, px_fire, fl_fire;
  logic                   px_phase_q, px_phase_d;
  flush_pos_t             fl_q, fl_d;

  logic [CW-1:0]          rd_addr [NCOPY];
  logic [1:0]             rd_data [NCOPY];
  logic                   ram_we;
  logic [1:0]             ram_wdata;

  logic                   mid, top;
  logic [2:0]             triple, wl, wm, wr;
  logic                   row_end;
  logic [RW-1:0]          row_m1;
  logic                   push_a, push_b;
  result_t                res_a, res_b;
  logic                   fifo_room;
  logic [LVW-1:0]         fifo_level;

  // configuration registers
  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_MODE:   mode_d   = filter_mode_e'(cfg_data_i[CFG_MODE_W-1:0]);
        CFG_IDX_WIDTH:  width_d  = cfg_data_i[CFG_DIM_W-1:0];
        CFG_IDX_HEIGHT: height_d = cfg_data_i[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign w_q = clamp_w(width_q);
  assign h_q = clamp_h(height_q);
  assign w_d = clamp_w(width_d);
  assign h_d = clamp_h(height_d);

  // handshake and phase
  assign pix_i.ready = fifo_room;
  assign in_fire     = pix_i.valid & pix_i.ready;
  assign px_phase_q  = (HW'(row_q) < h_q);
  assign px_fire     = in_fire && (op_e'(pix_i.op) == OP_PIXEL) && px_phase_q;
  assign fl_fire     = in_fire && (op_e'(pix_i.op) == OP_FLUSH) && !px_phase_q;
  assign fl_q        = flush_pos(fcol_q, w_q);

  // pixel path: new column triple into the window
  assign mid      = rd_data[0][0];
  assign top      = (row_q <= RW'(1)) ? mid : rd_data[0][1];
  assign triple   = {pix_i.pixel, mid, top};
  assign window_d = px_fire ? {triple, window_q[8:3]} : window_q;
  assign wl       = window_d[2:0];
  assign wm       = window_d[5:3];
  assign wr       = window_d[8:6];
  assign row_end  = (WW'(col_q) + WW'(1) >= w_q);
  assign row_m1   = row_q - RW'(1);

  // counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    fcol_d = fcol_q;
    if (px_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (fl_fire) begin
      if (fl_q.last) begin
        col_d  = '0;
        row_d  = '0;
        fcol_d = '0;
      end else begin
        fcol_d = fl_q.f + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      fcol_q   <= '0;
    end else begin
      window_q <= window_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fcol_q   <= fcol_d;
    end
  end

  // read addresses from next-state values
  assign px_phase_d = (HW'(row_d) < h_d);
  assign fl_d       = flush_pos(fcol_d, w_d);
  assign rd_addr[0] = px_phase_d ? col_d : fl_d.lf;
  assign rd_addr[1] = fl_d.f;
  assign rd_addr[2] = fl_d.rf;

  // line buffers: three identical copies so a flush tick sees three columns
  assign ram_we    = px_fire;
  assign ram_wdata = {mid, pix_i.pixel};

  for (genvar g = 0; g < NCOPY; g++) begin : g_line_buf
    bwf_ram #(
      .DATA_W (2),
      .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (col_q),
      .wdata_i (ram_wdata),
      .raddr_i (rd_addr[g]),
      .rdata_o (rd_data[g])
    );
  end

  // result formation
  always_comb begin
    res_a.value   = filter_px(mode_q, (col_q == CW'(1)) ? wm : wl, wm, wr,
                              (col_q == CW'(1)) || (WW'(col_q) >= w_q));
    res_a.out_row = ROW_W'(row_m1);
    res_a.out_col = COL_W'(col_q - CW'(1));
    res_a.last    = 1'b0;
    if (fl_fire) begin
      res_a.value   = filter_px(mode_q, buf_triple(rd_data[0]), buf_triple(rd_data[1]),
                                buf_triple(rd_data[2]), fl_q.border);
      res_a.out_col = COL_W'(fl_q.f);
      res_a.last    = fl_q.last;
    end
    res_b.value   = filter_px(mode_q, wm, wr, wr, 1'b1);
    res_b.out_row = ROW_W'(row_m1);
    res_b.out_col = COL_W'(col_q);
    res_b.last    = 1'b0;
  end

  assign push_a = (px_fire && (row_q != '0) && (col_q != '0)) || fl_fire;
  assign push_b = px_fire && (row_q != '0) && (col_q != '0) && row_end;

  bwf_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .push_b_i (push_b),
    .data_a_i (res_a),
    .data_b_i (res_b),
    .room_o   (fifo_room),
    .level_o  (fifo_level),
    .res_o    (res_o)
  );

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= LVW'(RES_DEPTH))
    else $error("result queue overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_b |-> (push_a && (res_b.out_col == res_a.out_col + COL_W'(1))))
    else $error("row-end pair out of column order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_fire && fl_q.last) |=> ((row_q == '0) && (col_q == '0) && (fcol_q == '0)))
    else $error("frame counters not cleared after final flush transfer");

endmodule

`default_nettype wire

### sim/binary_3x3_window_filter_top_tb.sv
`timescale 1ns / 1ps

module binary_3x3_window_filter_top_tb;
  import bwf_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_LIMIT   = 2000;

  typedef enum {RESIZE_NONE, RESIZE_ROWS, RESIZE_COLS} resize_e;

  // Mirror of the filter: line buffers, window and counters, plus the results still due
  class filtered_pixel_scoreboard;
    filter_mode_e         mode;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    bit                   above_row [MAX_W];
    bit                   two_above_row [MAX_W];
    logic [8:0]           window;
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    int unsigned          flush_col;
    result_t              pending_pixels[$];
    int unsigned          fail_count;

    function new();
      mode       = MODE_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      window     = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      flush_col  = 0;
      fail_count = 0;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_MODE:   mode = filter_mode_e'(data[CFG_MODE_W-1:0]);
        CFG_IDX_WIDTH:  width_reg = data;
        CFG_IDX_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    // Triples: bit 0 row above, bit 1 centre row, bit 2 row below
    function logic [VALUE_W-1:0] predict_filtered(logic [2:0] l, logic [2:0] m,
                                                  logic [2:0] r, bit border);
      int unsigned cnt;
      bit          cross_full;
      cnt        = $countones({r, m, l});
      cross_full = m[0] & m[2] & l[1] & r[1];
      case (mode)
        MODE_COUNT:     return VALUE_W'(cnt);
        MODE_MAJORITY:  return VALUE_W'(cnt > MAJORITY_MIN);
        MODE_RECT_EDGE: return VALUE_W'(m[1] && cnt < FULL_COUNT);
        default:        return VALUE_W'(!border && m[1] && !cross_full);
      endcase
    endfunction

    // Column rebuilt from the buffers for the final row: the row below replicates
    function logic [2:0] stored_column(int unsigned c);
      return {above_row[c], above_row[c], two_above_row[c]};
    endfunction

    function void push_pixel(logic [VALUE_W-1:0] v, int unsigned row, int unsigned col,
                             bit last);
      result_t res;
      res.value   = v;
      res.out_row = ROW_W'(row);
      res.out_col = COL_W'(col);
      res.last    = last;
      pending_pixels = {pending_pixels, res};
    endfunction

    function void note_item(op_e op, logic px);
      int unsigned w, h, c, f, lf, rf;
      bit          mid, top, at_end;
      logic [2:0]  wl, wm, wr;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      if (op == OP_PIXEL) begin
        // frame already complete: pixel dropped
        if (row_cnt >= h) return;
        c   = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
        mid = above_row[c];
        top = (row_cnt <= 1) ? mid : two_above_row[c];
        window = {px, mid, top, window[8:3]};
        two_above_row[c] = mid;
        above_row[c]     = px;
        if (row_cnt >= 1) begin
          wl = window[2:0];
          wm = window[5:3];
          wr = window[8:6];
          if (c >= 1)
            push_pixel(predict_filtered((c == 1) ? wm : wl, wm, wr, c == 1 || c >= w),
                       row_cnt - 1, c - 1, 1'b0);
          // row end: the last column leaves straight after its neighbour
          if (c + 1 >= w && c >= 1)
            push_pixel(predict_filtered(wm, wr, wr, 1'b1), row_cnt - 1, c, 1'b0);
        end
        col_cnt = c + 1;
        if (col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
        end
      end else begin
        // flush only counts once the whole frame is in
        if (row_cnt < h) return;
        f      = (flush_col > w - 1) ? w - 1 : flush_col;
        lf     = (f == 0) ? f : f - 1;
        rf     = (f + 1 < w) ? f + 1 : f;
        at_end = (f + 1 >= w);
        push_pixel(predict_filtered(stored_column(lf), stored_column(f), stored_column(rf),
                                    f == 0 || at_end), row_cnt - 1, f, at_end);
        if (at_end) begin
          flush_col = 0;
          col_cnt   = 0;
          row_cnt   = 0;
        end else begin
          flush_col = f + 1;
        end
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d row %0d col %0d",
                 $time, got.value, got.out_row, got.out_col);
        fail_count++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("value", 16'(want.value), 16'(got.value));
      compare_field("out_row", 16'(want.out_row), 16'(got.out_row));
      compare_field("out_col", 16'(want.out_col), 16'(got.out_col));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bwf_in_if  pix_if ();
  bwf_out_if res_if ();

  filtered_pixel_scoreboard pred;
  bit src_steady;
  bit sink_steady;
  int counted_items;
  int idle_cycles;

  binary_3x3_window_filter_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Result side back-pressure
  initial begin : result_sink
    int hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        hold = gap_len(sink_steady);
        res_if.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // Both transfer sides, sampled at the edge
  always @(posedge clk_i) begin : transfer_monitor
    result_t seen;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) pred.note_item(op_e'(pix_if.op), pix_if.pixel);
      if (res_if.valid && res_if.ready) begin
        seen.value   = res_if.value;
        seen.out_row = res_if.out_row;
        seen.out_col = res_if.out_col;
        seen.last    = res_if.last;
        pred.check_pixel(seen);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(op_e op, logic px);
    int gap;
    gap = gap_len(src_steady);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.op    <= op;
    pix_if.pixel <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  // Hold the stream until every result is back, then let the pipe empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pred.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    pred.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(filter_mode_e m, int wreg, int hreg);
    settle();
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(m));
    write_reg(CFG_IDX_WIDTH, CFG_DATA_W'(wreg));
    write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(hreg));
  endtask

  task automatic send_pixels(int n, logic [15:0] bits);
    for (int i = 0; i < n; i++) send_item(OP_PIXEL, bits[i]);
  endtask

  task automatic flush_frame(int n);
    repeat (n) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
    counted_items += n;
  endtask

  // One frame of random pixels, with optional stray items and a resize part-way
  task automatic run_frame(int w, int h, resize_e rs);
    int cols, cut_col, density, noise_at, new_w, roll;
    cols     = w;
    cut_col  = (w > 3) ? $urandom_range(3, w - 1) : 0;
    roll     = $urandom_range(0, 2);
    density  = (roll == 0) ? 10 : ((roll == 1) ? 50 : 90);
    noise_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w * h - 1) : -1;
    for (int r = 0; r < h; r++) begin
      // fewer rows: the frame ends now
      if (rs == RESIZE_ROWS && r == 3) begin
        settle();
        write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'($urandom_range(0, 3)));
        break;
      end
      for (int c = 0; c < cols; c++) begin
        // narrower rows: the current row ends at this pixel
        if (rs == RESIZE_COLS && r == 2 && c == cut_col) begin
          settle();
          new_w = $urandom_range(DIM_MIN, c);
          write_reg(CFG_IDX_WIDTH, CFG_DATA_W'(new_w));
          cols = new_w;
        end
        // early flush, dropped by the block
        if (r * w + c == noise_at) send_item(OP_FLUSH, 1'($urandom_range(0, 1)));
        send_item(OP_PIXEL, $urandom_range(0, 99) < density);
        counted_items++;
      end
    end
    // stray pixels once the frame is full, also dropped
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_item(OP_PIXEL, 1'($urandom_range(0, 1)));
    flush_frame(cols);
  endtask

  task automatic frame_with(filter_mode_e m, int wreg, int hreg, resize_e rs);
    set_config(m, wreg, hreg);
    run_frame(filtered_pixel_scoreboard::clamp_dim(wreg, MAX_W),
              filtered_pixel_scoreboard::clamp_dim(hreg, MAX_H), rs);
  endtask

  initial begin : stimulus
    int           wreg, hreg, w_eff, h_eff, roll;
    resize_e      rs;
    filter_mode_e m;
    pred          = new();
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    counted_items = 0;
    idle_cycles   = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_IDX_MODE;
    cfg_data_i    <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.op     <= OP_PIXEL;
    pix_if.pixel  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Box count on an all-set 2x2 frame, with an early flush and a stray pixel
    set_config(MODE_COUNT, 2, 2);
    send_item(OP_PIXEL, 1'b1);
    send_item(OP_FLUSH, 1'b1);
    send_pixels(3, 16'h0007);
    send_item(OP_PIXEL, 1'b0);
    flush_frame(2);

    // Majority on a mixed 2x2 frame
    set_config(MODE_MAJORITY, 2, 2);
    send_pixels(4, 16'h0006);
    flush_frame(2);

    // Rect edge, sizes below the minimum
    set_config(MODE_RECT_EDGE, 1, 0);
    send_pixels(4, 16'h000b);
    flush_frame(2);

    // Cross edge with one inner column
    set_config(MODE_CROSS_EDGE, 3, 2);
    send_pixels(6, 16'h0013);
    flush_frame(3);

    // Random frames, mostly small
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      m    = filter_mode_e'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      if (roll == 0) wreg = $urandom_range(0, 1);
      else if (roll == 1) wreg = $urandom_range(11, 32);
      else wreg = $urandom_range(2, 10);
      hreg  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      w_eff = filtered_pixel_scoreboard::clamp_dim(wreg, MAX_W);
      h_eff = filtered_pixel_scoreboard::clamp_dim(hreg, MAX_H);
      rs    = RESIZE_NONE;
      if ($urandom_range(0, 5) == 0) begin
        if (w_eff >= 4 && h_eff >= 3 && $urandom_range(0, 1) == 1) rs = RESIZE_COLS;
        else if (h_eff >= 4) rs = RESIZE_ROWS;
      end
      frame_with(m, wreg, hreg, rs);
    end

    settle();
    if (pred.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
